### rtl/core/plb_pkg.sv
`timescale 1ns / 1ps
package plb_pkg;

	localparam int MOM_WIDTH = 32;
	localparam int ROOT_W    = MOM_WIDTH;
	localparam int RAD_W     = 2 * MOM_WIDTH;
	localparam int REM_W     = ROOT_W + 3;
	localparam int DP_W      = MOM_WIDTH + 16;
	localparam int DOT_W     = DP_W + 2;
	localparam int D_W       = DOT_W - 14;
	localparam int D_LO_W    = D_W / 2;
	localparam int GB_W      = 24;
	localparam int KB_W      = GB_W + 1 + 16;
	localparam int KM_W      = GB_W + 1 + 16;
	localparam int TE_W      = GB_W + ROOT_W;
	localparam int TD_W      = GB_W + 1 + D_W;
	localparam int PB_W      = KB_W + ROOT_W / 2 + 1;
	localparam int PM_W      = KM_W + D_LO_W + 1;
	localparam int ACC_W     = 96;
	localparam int ADDR_W    = 5;

	typedef enum logic [2:0] {
		REG_BETA  = 3'd0,
		REG_GAMMA = 3'd1,
		REG_DIR_X = 3'd2,
		REG_DIR_Y = 3'd3,
		REG_DIR_Z = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic        clip;
		logic [31:0] val;
	} sat_t;

	function automatic sat_t sat32(input logic signed [ACC_W-1:0] v);
		sat_t r;
		if (v > ACC_W'(64'sh7FFF_FFFF)) begin
			r.clip = 1'b1;
			r.val  = 32'h7FFF_FFFF;
		end else if (v < -ACC_W'(64'sh8000_0000)) begin
			r.clip = 1'b1;
			r.val  = 32'h8000_0000;
		end else begin
			r.clip = 1'b0;
			r.val  = v[31:0];
		end
		return r;
	endfunction

endpackage

### rtl/core/photon_lorentz_boost.sv
`timescale 1ns / 1ps
// Lorentz boost of a photon three-momentum (Q16.16) along a programmed beam
// direction. The block takes one beat per cycle unless a held result waits on
// out_ready, and each beat passes through these stages: two stages form
// squares, dot product and sums, a 32-stage digit-by-digit square root
// pipeline yields the energy, and four stages do the split products, the
// sums, rounding and saturation. Stalls hold the whole pipeline. Write the
// registers only while no beat is in flight.
module photon_lorentz_boost (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [plb_pkg::ADDR_W-1:0]    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [31:0]            mom_x,
	input  logic signed [31:0]            mom_y,
	input  logic signed [31:0]            mom_z,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [31:0]            lab_energy,
	output logic signed [31:0]            lab_x,
	output logic signed [31:0]            lab_y,
	output logic signed [31:0]            lab_z,
	output logic                          saturated
);
	import plb_pkg::*;

	// configuration
	logic [15:0]             beta_q;
	logic [23:0]             gamma_q;
	logic signed [15:0]      dir_q [3];
	logic [GB_W-1:0]         gb_q;
	logic signed [KB_W-1:0]  kb_q [3];
	logic signed [KM_W-1:0]  km_q [3];
	logic signed [GB_W:0]    gm1;
	logic                    cfg_wr;
	reg_idx_t                cfg_idx;
	logic [39:0]             gb_full;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_q   <= '0;
			gamma_q  <= 24'd65536;
			dir_q[0] <= '0;
			dir_q[1] <= '0;
			dir_q[2] <= 16'sd16384;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_BETA:  beta_q   <= pwdata[15:0];
				REG_GAMMA: gamma_q  <= pwdata[23:0];
				REG_DIR_X: dir_q[0] <= pwdata[15:0];
				REG_DIR_Y: dir_q[1] <= pwdata[15:0];
				REG_DIR_Z: dir_q[2] <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_BETA:  prdata = {16'd0, beta_q};
			REG_GAMMA: prdata = {8'd0, gamma_q};
			REG_DIR_X: prdata = 32'(dir_q[0]);
			REG_DIR_Y: prdata = 32'(dir_q[1]);
			REG_DIR_Z: prdata = 32'(dir_q[2]);
			default:   prdata = '0;
		endcase
	end

	// derived coefficients are registered: gb_q and km_q from the registers, kb_q from gb_q
	assign gb_full = 40'(gamma_q) * 40'(beta_q);
	assign gm1     = $signed({1'b0, gamma_q}) - (GB_W+1)'(65536);

	always_ff @(posedge clk) begin
		gb_q <= gb_full[39:16];
		for (int i = 0; i < 3; i++) begin
			kb_q[i] <= KB_W'($signed({1'b0, gb_q})) * KB_W'(dir_q[i]);
			km_q[i] <= KM_W'(gm1) * KM_W'(dir_q[i]);
		end
	end

	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// stage 1: squares and direction products
	logic                    v_s1;
	logic signed [31:0]      p_s1  [3];
	logic [RAD_W-1:0]        sq_s1 [3];
	logic signed [DP_W-1:0]  dp_s1 [3];
	logic signed [31:0]      p_in  [3];
	logic [31:0]             m_in  [3];

	assign p_in[0] = mom_x;
	assign p_in[1] = mom_y;
	assign p_in[2] = mom_z;

	always_comb begin
		for (int i = 0; i < 3; i++)
			m_in[i] = p_in[i][31] ? 32'(-p_in[i]) : 32'(p_in[i]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				p_s1[i]  <= p_in[i];
				sq_s1[i] <= RAD_W'(m_in[i]) * RAD_W'(m_in[i]);
				dp_s1[i] <= DP_W'(dir_q[i]) * DP_W'(p_in[i]);
			end
		end
	end

	// square root pipeline, index 0 is the sum stage
	logic                     rt_v_s    [ROOT_W+1];
	logic [RAD_W-1:0]         rt_rad_s  [ROOT_W+1];
	logic [REM_W-1:0]         rt_rem_s  [ROOT_W+1];
	logic [ROOT_W-1:0]        rt_root_s [ROOT_W+1];
	logic signed [D_W-1:0]    rt_d_s    [ROOT_W+1];
	logic signed [31:0]       rt_p_s    [ROOT_W+1][3];
	logic [REM_W-1:0]         rem_nx    [ROOT_W];
	logic [ROOT_W-1:0]        root_nx   [ROOT_W];
	logic signed [DOT_W-1:0]  dot_sum;

	assign dot_sum = DOT_W'(dp_s1[0]) + DOT_W'(dp_s1[1]) + DOT_W'(dp_s1[2]);

	always_comb begin
		for (int k = 0; k < ROOT_W; k++) begin
			logic [REM_W-1:0] cur;
			logic [REM_W-1:0] trial;
			cur   = {rt_rem_s[k][REM_W-3:0], rt_rad_s[k][RAD_W-1-2*k -: 2]};
			trial = REM_W'({rt_root_s[k], 2'b01});
			if (cur >= trial) begin
				rem_nx[k]  = cur - trial;
				root_nx[k] = {rt_root_s[k][ROOT_W-2:0], 1'b1};
			end else begin
				rem_nx[k]  = cur;
				root_nx[k] = {rt_root_s[k][ROOT_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rt_rad_s[0]  <= sq_s1[0] + sq_s1[1] + sq_s1[2];
			rt_rem_s[0]  <= '0;
			rt_root_s[0] <= '0;
			rt_d_s[0]    <= dot_sum[DOT_W-1:14];
			rt_p_s[0]    <= p_s1;
			for (int k = 0; k < ROOT_W; k++) begin
				rt_rad_s[k+1]  <= rt_rad_s[k];
				rt_rem_s[k+1]  <= rem_nx[k];
				rt_root_s[k+1] <= root_nx[k];
				rt_d_s[k+1]    <= rt_d_s[k];
				rt_p_s[k+1]    <= rt_p_s[k];
			end
		end
	end

	// stage 3: split products
	logic                     v_s3;
	logic [TE_W-1:0]          te_s3;
	logic signed [TD_W-1:0]   td_s3;
	logic signed [PB_W-1:0]   pbl_s3 [3];
	logic signed [PB_W-1:0]   pbh_s3 [3];
	logic signed [PM_W-1:0]   pml_s3 [3];
	logic signed [PM_W-1:0]   pmh_s3 [3];
	logic signed [31:0]       p_s3   [3];
	logic [ROOT_W-1:0]        e_w;
	logic signed [D_W-1:0]    d_w;
	logic signed [ROOT_W/2:0] e_lo, e_hi;
	logic signed [D_LO_W:0]   d_lo;
	logic signed [D_W-D_LO_W-1:0] d_hi;

	assign e_w  = rt_root_s[ROOT_W];
	assign d_w  = rt_d_s[ROOT_W];
	assign e_lo = $signed({1'b0, e_w[ROOT_W/2-1:0]});
	assign e_hi = $signed({1'b0, e_w[ROOT_W-1:ROOT_W/2]});
	assign d_lo = $signed({1'b0, d_w[D_LO_W-1:0]});
	assign d_hi = d_w[D_W-1:D_LO_W];

	always_ff @(posedge clk) begin
		if (adv) begin
			te_s3 <= TE_W'(gamma_q) * TE_W'(e_w);
			td_s3 <= TD_W'($signed({1'b0, gb_q})) * TD_W'(d_w);
			p_s3  <= rt_p_s[ROOT_W];
			for (int i = 0; i < 3; i++) begin
				pbl_s3[i] <= PB_W'(kb_q[i]) * PB_W'(e_lo);
				pbh_s3[i] <= PB_W'(kb_q[i]) * PB_W'(e_hi);
				pml_s3[i] <= PM_W'(km_q[i]) * PM_W'(d_lo);
				pmh_s3[i] <= PM_W'(km_q[i]) * PM_W'(d_hi);
			end
		end
	end

	// stage 4: partial sums with rounding offsets
	logic                     v_s4;
	logic signed [ACC_W-1:0]  t_s4;
	logic signed [ACC_W-1:0]  xa_s4 [3];
	logic signed [ACC_W-1:0]  xb_s4 [3];
	logic signed [ACC_W-1:0]  xc_s4 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s4 <= ACC_W'($signed({1'b0, te_s3})) + ACC_W'(td_s3) + ACC_W'(1 << 15);
			for (int i = 0; i < 3; i++) begin
				xa_s4[i] <= ACC_W'(pbl_s3[i]) + (ACC_W'(pbh_s3[i]) <<< (ROOT_W / 2));
				xb_s4[i] <= ACC_W'(pml_s3[i]) + (ACC_W'(pmh_s3[i]) <<< D_LO_W);
				xc_s4[i] <= (ACC_W'(p_s3[i]) <<< 30) + ACC_W'(1 << 29);
			end
		end
	end

	// stage 5: final sums and scaling
	logic                     v_s5;
	logic signed [ACC_W-1:0]  t_s5;
	logic signed [ACC_W-1:0]  x_s5 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s5 <= t_s4 >>> 16;
			for (int i = 0; i < 3; i++)
				x_s5[i] <= (xa_s4[i] + xb_s4[i] + xc_s4[i]) >>> 30;
		end
	end

	// stage 6: saturation, output register
	sat_t st_t, st_x, st_y, st_z;
	assign st_t = sat32(t_s5);
	assign st_x = sat32(x_s5[0]);
	assign st_y = sat32(x_s5[1]);
	assign st_z = sat32(x_s5[2]);

	logic                 v_s6;
	logic signed [31:0]   lab_e_s6, lab_x_s6, lab_y_s6, lab_z_s6;
	logic                 sat_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			lab_e_s6 <= st_t.val;
			lab_x_s6 <= st_x.val;
			lab_y_s6 <= st_y.val;
			lab_z_s6 <= st_z.val;
			sat_s6   <= st_t.clip | st_x.clip | st_y.clip | st_z.clip;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int k = 0; k <= ROOT_W; k++)
				rt_v_s[k] <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1      <= in_valid;
			rt_v_s[0] <= v_s1;
			for (int k = 0; k < ROOT_W; k++)
				rt_v_s[k+1] <= rt_v_s[k];
			v_s3 <= rt_v_s[ROOT_W];
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	assign out_valid  = v_s6;
	assign lab_energy = lab_e_s6;
	assign lab_x      = lab_x_s6;
	assign lab_y      = lab_y_s6;
	assign lab_z      = lab_z_s6;
	assign saturated  = sat_s6;

`ifndef NO_ASSERTIONS
	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |->
			lab_energy == 32'sh7FFF_FFFF || lab_energy == 32'sh8000_0000 ||
			lab_x == 32'sh7FFF_FFFF || lab_x == 32'sh8000_0000 ||
			lab_y == 32'sh7FFF_FFFF || lab_y == 32'sh8000_0000 ||
			lab_z == 32'sh7FFF_FFFF || lab_z == 32'sh8000_0000)
		else $error("saturated flag without a clipped component");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> rt_v_s[ROOT_W] == $past(rt_v_s[ROOT_W]) &&
			v_s3 == $past(v_s3))
		else $error("pipeline moved during a stall");
`endif

endmodule
